>>> sv/npss_pkg.sv
// Shared types and constants for the nearest point scale selector.
`default_nettype none
package npss_pkg;
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic [1:0] REG_BASE_X = 2'd0;
	localparam logic [1:0] REG_BASE_Y = 2'd1;
	localparam logic [1:0] REG_BASE_Z = 2'd2;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic signed [15:0] point_z;
		logic signed [15:0] corner_x;
		logic signed [15:0] corner_y;
		logic signed [15:0] corner_z;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] scale_x;
		logic [31:0] scale_y;
		logic [31:0] scale_z;
		logic [4:0]  point_count;
	} out_word_t;

	// Handshake between the sequencer and the shared divider.
	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;
endpackage
`default_nettype wire

>>> sv/npss_divider.sv
// Restoring divider, one quotient bit per cycle, shared by the three axes.
`default_nettype none
module npss_divider
	import npss_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);
	logic [31:0] quo_q;
	logic [16:0] rem_q;
	logic [15:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] trial;
	logic [16:0] diff;

	always_comb begin
		trial = {rem_q[15:0], quo_q[31]};
		diff  = trial - {1'b0, dvs_q};
	end

	// Shift in one dividend bit, subtract when it fits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= (req.divisor == 16'd0) ? 16'd1 : req.divisor;
		end else if (busy_q) begin
			if (!diff[16]) begin
				rem_q <= diff;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
endmodule
`default_nettype wire

>>> sv/nearest_point_scale_selector_unit.sv
// Nearest point scale selector: sequencer, point table and shared divider.
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one word: add, remove
//   or query. Each word gives exactly one result word on out_valid/
//   out_ready/out_data. Configuration writes (cfg_valid/cfg_ready, cfg_index,
//   cfg_data) set the per-axis base sizes; issue them only while idle.
// Sequence (accepting edge to result word in the output register):
//   Add, unused code, empty query: straight to the output step. Remove: one
//   table entry compacted per cycle, then a closing step that sets the count.
//   Query: per stored entry, three squares on one squarer, then one compare;
//   then one division per axis on the one-bit-per-cycle divider (start, 32
//   bits, done), then the output step.
//   One word is processed at a time; in_ready is low until the result has
//   been placed in the output register and rises together with it.
// Reset: clears the point count and sets all base sizes to 1. Table contents
//   are left undefined; only entries below the count are ever used.
// Stall: a waiting result holds in the output register; the next input word
//   is accepted while it waits, but its result waits until the first leaves.
`default_nettype none
module nearest_point_scale_selector_unit
	import npss_pkg::*;
#(
	parameter int MAX_POINTS = 16
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_word_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_word_t      out_data,
	input  wire logic      cfg_valid,
	output logic           cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_REM    = 4'd1;
	localparam logic [3:0] S_QRD    = 4'd2;
	localparam logic [3:0] S_QSQ    = 4'd3;
	localparam logic [3:0] S_QCMP   = 4'd4;
	localparam logic [3:0] S_DIV    = 4'd5;
	localparam logic [3:0] S_DWAIT  = 4'd6;
	localparam logic [3:0] S_OUT    = 4'd7;

	logic [3:0]    state_q;
	in_word_t      cmd_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_q;
	logic [CW-1:0] kept_q;
	logic [15:0]   base_q [3];
	logic [47:0]   table_q [MAX_POINTS];
	logic [47:0]   ent_q;
	logic [1:0]    ax_q;
	logic [31:0]   sq_q [3];
	logic [31:0]   best_q [3];
	logic [33:0]   best_sum_q;
	logic          have_q;
	logic [31:0]   scl_q [3];
	logic [1:0]    status_q;
	out_word_t     res_q;
	logic          res_valid_q;
	div_req_t      dreq;
	div_rsp_t      drsp;

	logic signed [16:0] pa;
	logic signed [16:0] ca;
	logic signed [16:0] dd;
	logic [15:0]        mag;
	logic [31:0]        sq;
	logic [33:0]        sum;
	logic [47:0]        pkey;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = res_valid_q;
	assign out_data  = res_q;
	assign pkey = {cmd_q.point_x, cmd_q.point_y, cmd_q.point_z};

	// Shared squarer: one axis of the fetched entry per cycle.
	always_comb begin
		case (ax_q)
			2'd0: begin
				pa = {ent_q[47], ent_q[47:32]};
				ca = {cmd_q.corner_x[15], cmd_q.corner_x};
			end
			2'd1: begin
				pa = {ent_q[31], ent_q[31:16]};
				ca = {cmd_q.corner_y[15], cmd_q.corner_y};
			end
			default: begin
				pa = {ent_q[15], ent_q[15:0]};
				ca = {cmd_q.corner_z[15], cmd_q.corner_z};
			end
		endcase
		dd  = pa - ca;
		mag = dd[16] ? 16'(-dd) : dd[15:0];
		sq  = mag * mag;
		sum = {2'b0, sq_q[0]} + {2'b0, sq_q[1]} + {2'b0, sq_q[2]};
	end

	always_comb begin
		dreq.start    = (state_q == S_DIV);
		dreq.dividend = best_q[ax_q];
		dreq.divisor  = base_q[ax_q];
	end

	npss_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q[0] <= 16'd1;
			base_q[1] <= 16'd1;
			base_q[2] <= 16'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BASE_X: base_q[0] <= cfg_data;
				REG_BASE_Y: base_q[1] <= cfg_data;
				REG_BASE_Z: base_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Point table: one write port, one registered read.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && in_ready && in_data.operation == OP_ADD
			&& count_q < CW'(MAX_POINTS)) begin
			table_q[count_q[IW-1:0]] <= {in_data.point_x, in_data.point_y, in_data.point_z};
		end else if (state_q == S_REM && rd_q < count_q && ent_q != pkey) begin
			table_q[kept_q[IW-1:0]] <= ent_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && in_ready) begin
			ent_q <= table_q[0];
		end else if ((state_q == S_REM || state_q == S_QCMP) && rd_q + 1'b1 < count_q) begin
			ent_q <= table_q[IW'(rd_q + 1'b1)];
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// Drop the result word once taken, unless a new one loads now.
			if (res_valid_q && out_ready && state_q != S_OUT) res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						cmd_q    <= in_data;
						rd_q     <= '0;
						kept_q   <= '0;
						ax_q     <= 2'd0;
						have_q   <= 1'b0;
						scl_q[0] <= '0;
						scl_q[1] <= '0;
						scl_q[2] <= '0;
						case (in_data.operation)
							OP_ADD: begin
								if (count_q < CW'(MAX_POINTS)) begin
									count_q  <= count_q + 1'b1;
									status_q <= ST_OK;
								end else begin
									status_q <= ST_FULL;
								end
								state_q <= S_OUT;
							end
							OP_REMOVE: begin
								status_q <= ST_OK;
								state_q  <= S_REM;
							end
							OP_QUERY: begin
								if (count_q == '0) begin
									status_q <= ST_EMPTY;
									state_q  <= S_OUT;
								end else begin
									status_q <= ST_OK;
									state_q  <= S_QSQ;
								end
							end
							default: begin
								status_q <= ST_OK;
								state_q  <= S_OUT;
							end
						endcase
					end
				end
				S_REM: begin
					if (rd_q < count_q) begin
						if (ent_q != pkey) kept_q <= kept_q + 1'b1;
						rd_q <= rd_q + 1'b1;
					end else begin
						count_q <= kept_q;
						state_q <= S_OUT;
					end
				end
				S_QSQ: begin
					sq_q[ax_q] <= sq;
					if (ax_q == 2'd2) begin
						ax_q    <= 2'd0;
						state_q <= S_QCMP;
					end else begin
						ax_q <= ax_q + 2'd1;
					end
				end
				S_QCMP: begin
					if (!have_q || sum < best_sum_q) begin
						best_sum_q <= sum;
						best_q[0]  <= sq_q[0];
						best_q[1]  <= sq_q[1];
						best_q[2]  <= sq_q[2];
						have_q     <= 1'b1;
					end
					rd_q <= rd_q + 1'b1;
					if (rd_q + 1'b1 < count_q) state_q <= S_QSQ;
					else state_q <= S_DIV;
				end
				S_DIV: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (drsp.done) begin
						scl_q[ax_q] <= (drsp.quotient == '0) ? 32'd1 : drsp.quotient;
						if (ax_q == 2'd2) state_q <= S_OUT;
						else begin
							ax_q    <= ax_q + 2'd1;
							state_q <= S_DIV;
						end
					end
				end
				S_OUT: begin
					if (!res_valid_q || out_ready) begin
						res_q.status      <= status_q;
						res_q.scale_x     <= scl_q[0];
						res_q.scale_y     <= scl_q[1];
						res_q.scale_z     <= scl_q[2];
						res_q.point_count <= 5'(count_q);
						res_valid_q       <= 1'b1;
						state_q           <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> sv/npss_checker.sv
// Port-level checks for the nearest point scale selector, bound to the top level.
`default_nettype none
module npss_checker
	import npss_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_ready,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_word_t out_data
);
	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// An accepted word blocks further input for the next cycle.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken during work");

	// Count never exceeds sixteen.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.point_count <= 5'd16)
		else $error("point count out of range");

	// The x scale is zero on any word whose status is not OK.
	a_scale_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.scale_x == '0)
		else $error("scale on failed word");
endmodule

bind nearest_point_scale_selector_unit npss_checker u_npss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire

>>> dv/tb.sv
// Self-checking bench for the nearest point scale selector: directed table, then random traffic.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import npss_pkg::*;

	localparam int DEPTH = 16;
	localparam int CYCLE_LIMIT = 2000000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_word_t in_data;
	logic out_valid;
	logic out_ready;
	out_word_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	nearest_point_scale_selector_unit #(.MAX_POINTS(DEPTH)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predictor state: its own copy of table, count and base sizes.
	logic signed [15:0] pt_x [DEPTH];
	logic signed [15:0] pt_y [DEPTH];
	logic signed [15:0] pt_z [DEPTH];
	int unsigned pt_count;
	logic [15:0] base_x, base_y, base_z;

	out_word_t scale_queue[$];
	int errors;
	int unsigned cycles;
	int idle_in_pct, stall_out_pct;

	// Directed rows: a typed expectation is used where has_exp is set.
	typedef struct {
		in_word_t word;
		bit has_exp;
		out_word_t exp_word;
	} stim_row_t;
	stim_row_t rows[$];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic [31:0] axis_factor(input logic [33:0] dsq, input logic [15:0] base);
		logic [33:0] q;
		q = dsq / ((base == 16'd0) ? 34'd1 : {18'd0, base});
		return (q == 34'd0) ? 32'd1 : q[31:0];
	endfunction

	function automatic logic [33:0] sq_dist(input logic signed [15:0] a,
			input logic signed [15:0] b);
		logic signed [17:0] d;
		d = 18'(a) - 18'(b);
		if (d < 0) d = -d;
		return 34'(d) * 34'(d);
	endfunction

	// Apply one word to the predictor and return the expected result word.
	function automatic out_word_t predict_scale(input in_word_t w);
		out_word_t r;
		int unsigned kept;
		logic [33:0] dx, dy, dz, dsum, best, bx, by, bz;
		r = '0;
		r.status = ST_OK;
		case (w.operation)
			OP_ADD: begin
				if (pt_count < DEPTH) begin
					pt_x[pt_count] = w.point_x;
					pt_y[pt_count] = w.point_y;
					pt_z[pt_count] = w.point_z;
					pt_count++;
				end else begin
					r.status = ST_FULL;
				end
			end
			OP_REMOVE: begin
				kept = 0;
				for (int i = 0; i < pt_count; i++) begin
					if (!(pt_x[i] == w.point_x && pt_y[i] == w.point_y &&
							pt_z[i] == w.point_z)) begin
						pt_x[kept] = pt_x[i];
						pt_y[kept] = pt_y[i];
						pt_z[kept] = pt_z[i];
						kept++;
					end
				end
				pt_count = kept;
			end
			OP_QUERY: begin
				if (pt_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					best = '1;
					bx = '0;
					by = '0;
					bz = '0;
					for (int i = 0; i < pt_count; i++) begin
						dx = sq_dist(pt_x[i], w.corner_x);
						dy = sq_dist(pt_y[i], w.corner_y);
						dz = sq_dist(pt_z[i], w.corner_z);
						dsum = dx + dy + dz;
						if (i == 0 || dsum < best) begin
							best = dsum;
							bx = dx;
							by = dy;
							bz = dz;
						end
					end
					r.scale_x = axis_factor(bx, base_x);
					r.scale_y = axis_factor(by, base_y);
					r.scale_z = axis_factor(bz, base_z);
				end
			end
			default: ;
		endcase
		r.point_count = pt_count[4:0];
		return r;
	endfunction

	// Compare each accepted result word with the oldest expectation.
	always @(posedge clk) begin
		out_word_t exp_w;
		if (arst_n && out_valid && out_ready) begin
			if (scale_queue.size() == 0) begin
				$display("%0t: unexpected result word %p", $time, out_data);
				errors++;
			end else begin
				exp_w = scale_queue.pop_front();
				if (out_data !== exp_w) begin
					$display("%0t: mismatch expected %p actual %p", $time, exp_w, out_data);
					errors++;
				end
			end
		end
	end

	// Random receiver stall.
	always @(negedge clk) begin
		if (stall_out_pct == 0) out_ready <= 1'b1;
		else out_ready <= ($urandom_range(99) >= stall_out_pct);
	end

	function automatic logic signed [15:0] rand_coord();
		case ($urandom_range(5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'($urandom_range(15)) - 16'sd8;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_BASE_X: base_x = val;
			REG_BASE_Y: base_y = val;
			REG_BASE_Z: base_z = val;
			default: ;
		endcase
	endtask

	// Send one word; the expectation is queued at the accepting edge.
	task automatic send_word(input in_word_t w, input bit has_exp, input out_word_t exp_w);
		out_word_t p;
		@(negedge clk);
		while (idle_in_pct != 0 && $urandom_range(99) < idle_in_pct) @(negedge clk);
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		p = predict_scale(w);
		scale_queue = {scale_queue, (has_exp ? exp_w : p)};
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Drain, then allow for the longest query latency before touching registers.
	task automatic drain();
		while (scale_queue.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic in_word_t mk(input logic [1:0] op, input logic signed [15:0] x,
			input logic signed [15:0] y, input logic signed [15:0] z);
		in_word_t w;
		w.operation = op;
		w.point_x = x; w.point_y = y; w.point_z = z;
		w.corner_x = x; w.corner_y = y; w.corner_z = z;
		return w;
	endfunction

	function automatic out_word_t res(input logic [1:0] st, input int unsigned cnt);
		out_word_t r;
		r = '0;
		r.status = st;
		r.point_count = cnt[4:0];
		return r;
	endfunction

	task automatic add_row(input in_word_t w, input bit has_exp, input out_word_t e);
		stim_row_t r;
		r.word = w;
		r.has_exp = has_exp;
		r.exp_word = e;
		rows = {rows, r};
	endtask

	task automatic random_phase(input int n, input int idle, input int stall);
		in_word_t w;
		idle_in_pct = idle;
		stall_out_pct = stall;
		for (int i = 0; i < n; i++) begin
			w.operation = 2'($urandom_range(99) < 45 ? OP_QUERY :
				($urandom_range(99) < 60 ? OP_ADD : OP_REMOVE));
			if ($urandom_range(49) == 0) w.operation = OP_UNUSED;
			w.point_x = rand_coord();
			w.point_y = rand_coord();
			w.point_z = rand_coord();
			// Remove an existing entry most of the time so removals bite.
			if (w.operation == OP_REMOVE && pt_count != 0 && $urandom_range(3) != 0) begin
				int unsigned k;
				k = $urandom_range(pt_count - 1);
				w.point_x = pt_x[k]; w.point_y = pt_y[k]; w.point_z = pt_z[k];
			end
			w.corner_x = rand_coord();
			w.corner_y = rand_coord();
			w.corner_z = rand_coord();
			send_word(w, 1'b0, '0);
		end
		drain();
	endtask

	initial begin
		out_word_t none;
		in_word_t w;
		none = '0;
		errors = 0;
		cycles = 0;
		idle_in_pct = 0;
		stall_out_pct = 0;
		pt_count = 0;
		base_x = 16'd1; base_y = 16'd1; base_z = 16'd1;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b1;
		cfg_valid = 1'b0;
		cfg_index = REG_BASE_X;
		cfg_data = 16'd1;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table: empty query, extremes, full table, removal, unused code.
		add_row(mk(OP_QUERY, 16'sd0, 16'sd0, 16'sd0), 1, res(ST_EMPTY, 0));
		add_row(mk(OP_REMOVE, 16'sd5, 16'sd5, 16'sd5), 1, res(ST_OK, 0));
		add_row(mk(OP_ADD, 16'sh7fff, 16'sh7fff, 16'sh7fff), 1, res(ST_OK, 1));
		w = mk(OP_QUERY, 16'sh8000, 16'sh8000, 16'sh8000);
		add_row(w, 1, '{status: ST_OK, scale_x: 32'hfffe0001, scale_y: 32'hfffe0001,
			scale_z: 32'hfffe0001, point_count: 5'd1});
		add_row(mk(OP_QUERY, 16'sh7fff, 16'sh7fff, 16'sh7fff), 0, none);
		add_row(mk(OP_ADD, 16'sh8000, 16'sh8000, 16'sh8000), 1, res(ST_OK, 2));
		add_row(mk(OP_QUERY, 16'sd0, 16'sd0, 16'sd0), 0, none);
		add_row(mk(OP_UNUSED, 16'sd1, 16'sd1, 16'sd1), 1, res(ST_OK, 2));
		for (int i = 0; i < 14; i++)
			add_row(mk(OP_ADD, 16'sd3, 16'sd3, 16'sd3), 1, res(ST_OK, 3 + i));
		add_row(mk(OP_ADD, 16'sd9, 16'sd9, 16'sd9), 1, res(ST_FULL, 16));
		add_row(mk(OP_QUERY, 16'sd3, 16'sd4, 16'sd2), 0, none);
		add_row(mk(OP_REMOVE, 16'sd3, 16'sd3, 16'sd3), 1, res(ST_OK, 2));
		foreach (rows[i]) send_word(rows[i].word, rows[i].has_exp, rows[i].exp_word);
		drain();

		// Zero divisors, then largest, then mixed, across input-idle and output-stall phases.
		write_reg(REG_BASE_X, 16'd0);
		write_reg(REG_BASE_Y, 16'd0);
		write_reg(REG_BASE_Z, 16'd0);
		random_phase(150, 0, 0);
		write_reg(REG_BASE_X, 16'hffff);
		write_reg(REG_BASE_Y, 16'hffff);
		write_reg(REG_BASE_Z, 16'hffff);
		random_phase(150, 73, 0);
		write_reg(REG_BASE_X, 16'($urandom_range(1, 65535)));
		write_reg(REG_BASE_Y, 16'd1);
		write_reg(REG_BASE_Z, 16'($urandom_range(1, 300)));
		random_phase(150, 0, 73);
		write_reg(REG_BASE_X, 16'd7);
		write_reg(REG_BASE_Y, 16'($urandom));
		write_reg(REG_BASE_Z, 16'd1);
		random_phase(150, 26, 26);

		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire

>>> files.f
sv/npss_pkg.sv
sv/npss_divider.sv
sv/nearest_point_scale_selector_unit.sv
sv/npss_checker.sv
dv/tb.sv
